// ===== rtl/ntew_pkg.sv =====
package ntew_pkg;

  localparam int VALUE_W    = 31;
  localparam int IN_TDATA_W = 32;
  localparam int WORD_W     = 5;
  localparam int OUT_TDATA_W = 8;
  localparam int BCD_DIGITS = 12;
  localparam int BCD_W      = 4 * BCD_DIGITS;
  localparam int GROUPS     = 4;
  localparam int CNT_W      = $clog2(VALUE_W);

  localparam logic [WORD_W-1:0] TOK_ZERO      = 5'd0;
  localparam logic [WORD_W-1:0] TOK_TENS_BASE = 5'd18;
  localparam logic [WORD_W-1:0] TOK_HUNDRED   = 5'd28;
  localparam logic [WORD_W-1:0] TOK_THOUSAND  = 5'd29;
  localparam logic [WORD_W-1:0] TOK_MILLION   = 5'd30;
  localparam logic [WORD_W-1:0] TOK_BILLION   = 5'd31;

  // group indexes, most significant first
  localparam logic [1:0] GRP_BILLION  = 2'd0;
  localparam logic [1:0] GRP_MILLION  = 2'd1;
  localparam logic [1:0] GRP_THOUSAND = 2'd2;
  localparam logic [1:0] GRP_UNITS    = 2'd3;

  // steps within one group
  localparam logic [2:0] STP_HUND_DIGIT = 3'd0;
  localparam logic [2:0] STP_HUND_WORD  = 3'd1;
  localparam logic [2:0] STP_TENS       = 3'd2;
  localparam logic [2:0] STP_UNITS      = 3'd3;
  localparam logic [2:0] STP_SCALE      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SPELL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       shift;
    logic       step;
    logic       finish;
    logic [1:0] grp;
    logic [2:0] stp;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/ntew_ctrl.sv =====
module ntew_ctrl
  import ntew_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       grp, grp_next;
  logic [2:0]       stp, stp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      grp   <= GRP_BILLION;
      stp   <= STP_HUND_DIGIT;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      grp   <= grp_next;
      stp   <= stp_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    grp_next   = grp;
    stp_next   = stp;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.grp    = grp;
    cmd.stp    = stp;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          grp_next   = GRP_BILLION;
          stp_next   = STP_HUND_DIGIT;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.shift = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_W - 1)) begin
          state_next = ST_SPELL;
        end
      end
      ST_SPELL: begin
        // every step may push a word, so wait for room downstream
        if (stat.out_free) begin
          cmd.step = 1'b1;
          if (stp == STP_SCALE) begin
            stp_next = STP_HUND_DIGIT;
            if (grp == GRP_UNITS) begin
              state_next = ST_FINISH;
            end else begin
              grp_next = grp + 1'b1;
            end
          end else begin
            stp_next = stp + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/ntew_dp.sv =====
module ntew_dp
  import ntew_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [VALUE_W-1:0] value,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [WORD_W-1:0]  word,
  output logic               last
);

  logic [VALUE_W-1:0] bin;
  logic [BCD_W-1:0]   bcd;
  logic [BCD_W-1:0]   bcd_adj;
  logic [11:0]        grp_digits;
  logic [3:0]         hd, td, ud;
  logic               tok_en;
  logic [WORD_W-1:0]  tok;
  logic [WORD_W-1:0]  held;
  logic               held_valid;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= value;
      bcd <= '0;
    end else if (cmd.shift) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
  end

  always_comb begin
    unique case (cmd.grp)
      GRP_BILLION:  grp_digits = bcd[47:36];
      GRP_MILLION:  grp_digits = bcd[35:24];
      GRP_THOUSAND: grp_digits = bcd[23:12];
      GRP_UNITS:    grp_digits = bcd[11:0];
      default:      grp_digits = bcd[11:0];
    endcase
  end

  assign hd = grp_digits[11:8];
  assign td = grp_digits[7:4];
  assign ud = grp_digits[3:0];

  always_comb begin
    tok_en = 1'b0;
    tok    = TOK_ZERO;
    unique case (cmd.stp)
      STP_HUND_DIGIT: begin
        tok_en = (hd != 4'd0);
        tok    = {1'b0, hd};
      end
      STP_HUND_WORD: begin
        tok_en = (hd != 4'd0);
        tok    = TOK_HUNDRED;
      end
      STP_TENS: begin
        if (td >= 4'd2) begin
          tok_en = 1'b1;
          tok    = TOK_TENS_BASE + {1'b0, td};
        end else begin
          // one to nineteen as a single word
          tok_en = (td != 4'd0) || (ud != 4'd0);
          tok    = td[0] ? (5'd10 + {1'b0, ud}) : {1'b0, ud};
        end
      end
      STP_UNITS: begin
        tok_en = (td >= 4'd2) && (ud != 4'd0);
        tok    = {1'b0, ud};
      end
      STP_SCALE: begin
        tok_en = (grp_digits != 12'd0) && (cmd.grp != GRP_UNITS);
        priority case (cmd.grp)
          GRP_BILLION: tok = TOK_BILLION;
          GRP_MILLION: tok = TOK_MILLION;
          default:     tok = TOK_THOUSAND;
        endcase
      end
      default: begin
        tok_en = 1'b0;
        tok    = TOK_ZERO;
      end
    endcase
  end

  assign stat.out_free = !out_valid || out_ready;

  // one word is held back so that the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        held_valid <= 1'b0;
      end else if (cmd.step && tok_en) begin
        held_valid <= 1'b1;
      end else if (cmd.finish) begin
        held_valid <= 1'b0;
      end
      if ((cmd.step && tok_en && held_valid) || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && tok_en) begin
      held <= tok;
      if (held_valid) begin
        word <= held;
        last <= 1'b0;
      end
    end else if (cmd.finish) begin
      word <= held_valid ? held : TOK_ZERO;
      last <= 1'b1;
    end
  end

endmodule

// ===== rtl/number_to_english_word_tokens_top.sv =====
// channel  | dir | tdata                    | tuser | tlast
// s_axis   | in  | [30:0] value, [31] zero  | -     | -
// m_axis   | out | [4:0] word, [7:5] zero   | -     | last word of a value
//
// a value is accepted, then passes 31 shift-add steps of the binary to
// decimal converter and 20 spelling steps (5 per three-digit group) before
// the final word is released; spelling and release wait while m_axis stalls.
// a new value is taken only when the controller is idle; the last word of
// the previous value may still wait in the output register.
// rst is synchronous and clears the controller and the valid flags.
module number_to_english_word_tokens_top
  import ntew_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // value
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // word
  output logic                   m_axis_tlast
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [WORD_W-1:0] word;

  ntew_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ntew_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (s_axis_tdata[VALUE_W-1:0]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .word      (word),
    .last      (m_axis_tlast)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - WORD_W){1'b0}}, word};

endmodule

// ===== rtl/ntew_checker.sv =====
module ntew_checker
  import ntew_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // a held word stays put
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // reset leaves the block ready and empty
  assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after reset");

  // one value at a time
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second value taken during conversion");

  // a zero word is always the final word of its value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[WORD_W-1:0] == TOK_ZERO) |-> m_axis_tlast)
    else $error("zero not marked as final word");

endmodule

bind number_to_english_word_tokens_top ntew_checker u_ntew_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ntew_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
  } word_tok_t;

  // keeps the spelled-out words of every accepted value, oldest first
  class spelling_board;
    word_tok_t         expected_words[$];
    logic [WORD_W-1:0] draft[$];
    int unsigned       mismatches;

    function new();
      mismatches = 0;
    endfunction

    task flag_mismatch(input string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function void spell_group(input int unsigned grp, input logic [WORD_W-1:0] scale,
                              input bit has_scale);
      int unsigned h;
      int unsigned r;
      if (grp == 0) return;
      h = grp / 100;
      r = grp % 100;
      if (h != 0) begin
        draft.push_back(WORD_W'(h));
        draft.push_back(TOK_HUNDRED);
      end
      if (r >= 20) begin
        draft.push_back(TOK_TENS_BASE + WORD_W'(r / 10));
        if (r % 10 != 0) draft.push_back(WORD_W'(r % 10));
      end else if (r != 0) begin
        draft.push_back(WORD_W'(r));
      end
      if (has_scale) draft.push_back(scale);
    endfunction

    function void note_value(input logic [VALUE_W-1:0] value);
      int unsigned v;
      word_tok_t   tok;
      v = {1'b0, value};
      draft.delete();
      if (v == 0) begin
        draft.push_back(TOK_ZERO);
      end else begin
        spell_group(v / 1000000000, TOK_BILLION, 1'b1);
        spell_group((v / 1000000) % 1000, TOK_MILLION, 1'b1);
        spell_group((v / 1000) % 1000, TOK_THOUSAND, 1'b1);
        spell_group(v % 1000, TOK_ZERO, 1'b0);
      end
      foreach (draft[k]) begin
        tok.word = draft[k];
        tok.last = (k == draft.size() - 1);
        expected_words.push_back(tok);
      end
    endfunction

    task check_word(input logic [WORD_W-1:0] word, input logic last);
      word_tok_t want;
      if (expected_words.size() == 0) begin
        flag_mismatch($sformatf("word %0d last %0b with no value pending", word, last));
      end else begin
        want = expected_words.pop_front();
        if (word !== want.word)
          flag_mismatch($sformatf("word got %0d want %0d", word, want.word));
        if (last !== want.last)
          flag_mismatch($sformatf("last got %0b want %0b (word %0d)", last, want.last,
                                  want.word));
      end
    endtask

    function int unsigned outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [30:0] value, [31] zero
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [4:0] word, [7:5] zero
  logic                   m_axis_tlast;

  spelling_board sb;
  bit            stall_on = 1'b0;
  bit            gaps_on = 1'b1;
  int unsigned   ready_hold = 0;
  int unsigned   ready_roll = 0;
  int unsigned   corner_values[25] = '{
    0, 1, 7, 9, 10, 13, 19, 20, 21, 45, 99, 100, 101, 115, 120, 999, 1000,
    1000000, 1000000000, 1000000001, 1001001001, 1010101010, 999999999,
    2000000000, 2147483647
  };

  number_to_english_word_tokens_top DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // output side backpressure: mostly short stalls, now and then a long one
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!stall_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        m_axis_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 4);
      end else if (ready_roll < 95) begin
        m_axis_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata[WORD_W-1:0], m_axis_tlast);
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_value(input logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, value};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_value(value);
  endtask

  function automatic int unsigned pick_group();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) return 0;
    if (roll < 45) return $urandom_range(0, 19);
    if (roll < 55) return 100 * $urandom_range(1, 9) + $urandom_range(10, 19);
    return $urandom_range(0, 999);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned roll;
    longint      v;
    roll = $urandom_range(0, 99);
    if (roll < 45) begin
      // three-digit groups with many all-zero groups in between
      v = longint'($urandom_range(0, 2)) * 1000000000 + longint'(pick_group()) * 1000000
          + longint'(pick_group()) * 1000 + pick_group();
      if (v > 2147483647) v -= 1000000000;
    end else if (roll < 70) begin
      v = $urandom & 32'h7fff_ffff;
    end else if (roll < 90) begin
      v = $urandom_range(0, 999);
    end else begin
      v = $urandom_range(0, 20);
    end
    return v[VALUE_W-1:0];
  endfunction

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    stall_on = 1'b1;
    foreach (corner_values[i]) send_value(corner_values[i][VALUE_W-1:0]);

    // a stretch with no idling on either side, then full random idling
    stall_on = 1'b0;
    gaps_on = 1'b0;
    repeat (50) send_value(pick_value());
    stall_on = 1'b1;
    gaps_on = 1'b1;
    repeat (150) send_value(pick_value());
    s_axis_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d words outstanding", sb.outstanding());
    $display("== FAIL ==");
    $finish;
  end

endmodule
